// ===== design/gfba_pkg.sv =====
`timescale 1ns / 1ps
// Package for the grouped free-block allocator: field widths, function and
// status codes, controller states and the result record. No dependencies.
package gfba_pkg;

	localparam int BLK_W = 16;
	localparam int CNT_W = 17;
	localparam logic [CNT_W-1:0] FREE_MAX = 17'd65536;

	typedef enum logic [1:0] {
		FN_ALLOC = 2'd0,
		FN_FREE  = 2'd1,
		FN_FILL  = 2'd2,
		FN_RSVD  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_GRANTED    = 3'd0,
		ST_NO_SPACE   = 3'd1,
		ST_SPILL      = 3'd2,
		ST_FREED      = 3'd3,
		ST_FILL_TAKEN = 3'd4,
		ST_BUSY       = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_GRANT,
		S_SPILL
	} ctrl_state_t;

	typedef struct packed {
		status_t           status;
		logic [BLK_W-1:0]  block;
		logic [BLK_W-1:0]  word;
		logic              fill_needed;
		logic [CNT_W-1:0]  count;
		logic              last;
	} result_t;

endpackage

// ===== design/gfba_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package needed.
module gfba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/gfba_out.sv =====
`timescale 1ns / 1ps
// Output register for result transactions of the allocator.
// Depends on gfba_pkg for the result record.
module gfba_out
	import gfba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  result_t          res,
	output logic             can_load,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       status,
	output logic [BLK_W-1:0] block_out,
	output logic [BLK_W-1:0] spill_word,
	output logic             fill_needed,
	output logic [CNT_W-1:0] free_count,
	output logic             last
);

	logic    valid_q;
	result_t res_q;

	// slot is free when empty or being drained this cycle
	assign can_load = !valid_q || out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (can_load && load) begin
			res_q <= res;
		end
	end

	assign out_valid   = valid_q;
	assign status      = res_q.status;
	assign block_out   = res_q.block;
	assign spill_word  = res_q.word;
	assign fill_needed = res_q.fill_needed;
	assign free_count  = res_q.count;
	assign last        = res_q.last;

endmodule

// ===== design/gfba_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the allocator: top index, free count, refill tracker and the
// read-modify-write sequencing of the stack memory. Depends on gfba_pkg.
module gfba_ctrl
	import gfba_pkg::*;
#(
	parameter int GROUP_SIZE     = 16,
	parameter int BLOCK_NUM_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    func,
	input  logic [BLK_W-1:0]              block_in,
	input  logic [BLK_W-1:0]              fill_word,
	input  logic                          can_load,
	output logic                          res_load,
	output result_t                       res,
	output logic                          mem_we,
	output logic [$clog2(GROUP_SIZE)-1:0] mem_waddr,
	output logic [BLK_W-1:0]              mem_wdata,
	output logic                          mem_re,
	output logic [$clog2(GROUP_SIZE)-1:0] mem_raddr,
	input  logic [BLK_W-1:0]              mem_rdata
);

	localparam int IDX_W = $clog2(GROUP_SIZE);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GROUP_SIZE - 1);
	localparam int MASK_BITS = (BLOCK_NUM_BITS > BLK_W) ? BLK_W : BLOCK_NUM_BITS;
	localparam logic [BLK_W-1:0] BLK_MASK = {BLK_W{1'b1}} >> (BLK_W - MASK_BITS);

	ctrl_state_t      state_q, state_d;
	logic [IDX_W-1:0] top_q;
	logic [CNT_W-1:0] free_total_q;
	logic [IDX_W-1:0] fill_pos_q;
	logic             filling_q;
	logic             e0_valid_q;
	logic [IDX_W-1:0] spill_idx_q;
	logic [BLK_W-1:0] spill_blk_q;
	logic [IDX_W-1:0] rd_addr_q;

	logic             accept;
	logic [BLK_W-1:0] blk_m;
	logic [BLK_W-1:0] word_m;
	logic [CNT_W-1:0] count_inc;
	logic [CNT_W-1:0] count_dec;
	logic [BLK_W-1:0] rd_word;
	logic             is_fill, is_alloc, is_free, is_spill, is_push;
	logic             no_space;
	logic             spill_last;
	logic             do_fill, do_push, do_spill_start, do_grant, spill_step;

	// input handshake and field conditioning
	assign in_ready = (state_q == S_IDLE) && can_load;
	assign accept   = in_valid && in_ready;
	assign blk_m    = block_in & BLK_MASK;
	assign word_m   = fill_word & BLK_MASK;

	// saturating count neighbors
	assign count_inc = (free_total_q < FREE_MAX) ? free_total_q + 1'b1 : free_total_q;
	assign count_dec = (free_total_q != '0) ? free_total_q - 1'b1 : free_total_q;

	// entry 0 reads as zero until first written
	assign rd_word = (rd_addr_q == '0 && !e0_valid_q) ? '0 : mem_rdata;

	// operation classes
	assign is_fill  = (func_t'(func) == FN_FILL) && filling_q;
	assign is_alloc = (func_t'(func) == FN_ALLOC) && !filling_q;
	assign is_free  = (func_t'(func) == FN_FREE) && !filling_q;
	assign is_spill = is_free && (top_q == LAST_IDX);
	assign is_push  = is_free && (top_q != LAST_IDX);

	assign no_space   = (top_q == '0) && (rd_word == '0);
	assign spill_last = (spill_idx_q == LAST_IDX);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && is_alloc) begin
					state_d = S_GRANT;
				end else if (accept && is_spill) begin
					state_d = S_SPILL;
				end
			end
			S_GRANT: begin
				if (can_load) begin
					state_d = S_IDLE;
				end
			end
			S_SPILL: begin
				if (can_load && spill_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory, result and update controls
	always_comb begin
		res_load        = 1'b0;
		res             = '0;
		res.status      = ST_BUSY;
		res.count       = free_total_q;
		res.last        = 1'b1;
		mem_we          = 1'b0;
		mem_waddr       = '0;
		mem_wdata       = '0;
		mem_re          = 1'b0;
		mem_raddr       = '0;
		do_fill         = 1'b0;
		do_push         = 1'b0;
		do_spill_start  = 1'b0;
		do_grant        = 1'b0;
		spill_step      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_fill) begin
						do_fill    = 1'b1;
						mem_we     = 1'b1;
						mem_waddr  = fill_pos_q;
						mem_wdata  = word_m;
						res_load   = 1'b1;
						res.status = ST_FILL_TAKEN;
					end else if (is_alloc) begin
						mem_re    = 1'b1;
						mem_raddr = top_q;
					end else if (is_push) begin
						do_push    = 1'b1;
						mem_we     = 1'b1;
						mem_waddr  = top_q + 1'b1;
						mem_wdata  = blk_m;
						res_load   = 1'b1;
						res.status = ST_FREED;
						res.block  = blk_m;
						res.count  = count_inc;
					end else if (is_spill) begin
						do_spill_start = 1'b1;
						mem_re         = 1'b1;
						mem_raddr      = '0;
					end else begin
						res_load = 1'b1;
					end
				end
			end
			S_GRANT: begin
				if (can_load) begin
					res_load = 1'b1;
					if (no_space) begin
						res.status = ST_NO_SPACE;
					end else begin
						do_grant        = 1'b1;
						res.status      = ST_GRANTED;
						res.block       = rd_word;
						res.fill_needed = (top_q == '0);
						res.count       = count_dec;
					end
				end
			end
			S_SPILL: begin
				if (can_load) begin
					spill_step = 1'b1;
					res_load   = 1'b1;
					res.status = ST_SPILL;
					res.block  = spill_blk_q;
					res.word   = rd_word;
					res.last   = spill_last;
					if (spill_last) begin
						// stack restarts with the freed block alone
						mem_we    = 1'b1;
						mem_waddr = '0;
						mem_wdata = spill_blk_q;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = spill_idx_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			top_q        <= '0;
			free_total_q <= '0;
			fill_pos_q   <= '0;
			filling_q    <= 1'b0;
			e0_valid_q   <= 1'b0;
			spill_idx_q  <= '0;
		end else begin
			state_q <= state_d;
			if (do_fill) begin
				if (fill_pos_q == '0) begin
					e0_valid_q <= 1'b1;
				end
				if (fill_pos_q == LAST_IDX) begin
					fill_pos_q <= '0;
					filling_q  <= 1'b0;
				end else begin
					fill_pos_q <= fill_pos_q + 1'b1;
				end
			end
			if (do_push) begin
				top_q        <= top_q + 1'b1;
				free_total_q <= count_inc;
			end
			if (do_spill_start) begin
				free_total_q <= count_inc;
				spill_idx_q  <= '0;
			end
			if (do_grant) begin
				free_total_q <= count_dec;
				if (top_q == '0) begin
					top_q      <= LAST_IDX;
					filling_q  <= 1'b1;
					fill_pos_q <= '0;
				end else begin
					top_q <= top_q - 1'b1;
				end
			end
			if (spill_step) begin
				spill_idx_q <= spill_idx_q + 1'b1;
				if (spill_last) begin
					top_q      <= '0;
					e0_valid_q <= 1'b1;
				end
			end
		end
	end

	// read address tracking and spill target
	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_addr_q <= mem_raddr;
		end
		if (do_spill_start) begin
			spill_blk_q <= blk_m;
		end
	end

endmodule

// ===== design/grouped_free_block_allocator.sv =====
`timescale 1ns / 1ps
// Top level of the grouped free-block allocator: stack memory, controller and
// result register. Depends on gfba_pkg, gfba_ram, gfba_ctrl and gfba_out.
//
//  channel | handshake            | fields
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | func, block_in, fill_word
//  out     | out_valid / out_ready| status, block_out, spill_word, fill_needed,
//          |                      | free_count, last
//
// Free, refill and rejected transactions load their result when accepted; an
// allocation loads it from the registered stack memory read. A free into a full
// stack reads the stack memory out, one result per cycle while out_ready allows.
// Reset clears all control state; there is no clearing pass, entry 0 reads as
// zero until first written. Input is taken only when the controller is idle and
// the result register is free or draining; out_ready low stalls everything.
module grouped_free_block_allocator
	import gfba_pkg::*;
#(
	parameter int GROUP_SIZE     = 16,
	parameter int BLOCK_NUM_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       func,
	input  logic [BLK_W-1:0] block_in,
	input  logic [BLK_W-1:0] fill_word,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       status,
	output logic [BLK_W-1:0] block_out,
	output logic [BLK_W-1:0] spill_word,
	output logic             fill_needed,
	output logic [CNT_W-1:0] free_count,
	output logic             last
);

	localparam int IDX_W = $clog2(GROUP_SIZE);

	logic             can_load;
	logic             res_load;
	result_t          res;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [BLK_W-1:0] mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	logic [BLK_W-1:0] mem_rdata;

	// free block stack
	gfba_ram #(
		.WIDTH (BLK_W),
		.DEPTH (GROUP_SIZE)
	) u_stack (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// sequencing and bookkeeping
	gfba_ctrl #(
		.GROUP_SIZE     (GROUP_SIZE),
		.BLOCK_NUM_BITS (BLOCK_NUM_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.block_in  (block_in),
		.fill_word (fill_word),
		.can_load  (can_load),
		.res_load  (res_load),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// result register
	gfba_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (res_load),
		.res         (res),
		.can_load    (can_load),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.block_out   (block_out),
		.spill_word  (spill_word),
		.fill_needed (fill_needed),
		.free_count  (free_count),
		.last        (last)
	);

endmodule
